FILE: hw/rtl/pose_frame_deframer_core_macros.svh
// Assertion macros shared by the pose frame deframer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef POSE_FRAME_DEFRAMER_CORE_MACROS_SVH
`define POSE_FRAME_DEFRAMER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define PFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfd assertion failed");

`else

`define PFD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/pfd_pkg.sv
// Shared types and constants of the pose frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pfd_pkg;

    // Window geometry.
    localparam int FRAME_BYTES = 32;
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    // Frame delimiters and checksum seed.
    localparam logic [7:0] SYNC_HEAD = 8'h40;
    localparam logic [7:0] SYNC_TAIL = 8'h2B;
    localparam logic [7:0] SUM_SEED  = 8'd19;

    // Bytes covered by the checksum.
    localparam int SUM_FIRST = 3;
    localparam int SUM_LAST  = FRAME_BYTES - 2;
    localparam int SUM_BYTES = SUM_LAST - SUM_FIRST + 1;

    // Register indexes on the configuration port.
    localparam logic REG_DEVICE_ID = 1'b0;

    // Frame status codes.
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // One result item.
    typedef struct packed {
        logic        frame_status;
        logic [31:0] pos_x_bits;
        logic [31:0] pos_y_bits;
        logic [31:0] pos_z_bits;
        logic [31:0] quat_w_bits;
        logic [31:0] quat_x_bits;
        logic [31:0] quat_y_bits;
        logic [31:0] quat_z_bits;
    } t_result;

endpackage

FILE: hw/rtl/pose_frame_deframer_core.sv
// Pose frame deframer: 32-byte receive window, frame check and pose extraction.
// A result is written into the result queue when the byte that closes the frame is accepted.
// Throughput: one byte per cycle, window update and XOR tree finishing in that cycle;
// the input stalls only while both entries of the two-deep result queue are occupied.
// Reset (synchronous, active low) clears the window, the fill count, device_id and the queue.
// Depends on pfd_pkg, pfd_out_fifo and the assertion macro header.
`timescale 1ns / 1ps
`include "pose_frame_deframer_core_macros.svh"

module pose_frame_deframer_core
    import pfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_frame_status,
    output logic [31:0] o_pos_x_bits,
    output logic [31:0] o_pos_y_bits,
    output logic [31:0] o_pos_z_bits,
    output logic [31:0] o_quat_w_bits,
    output logic [31:0] o_quat_x_bits,
    output logic [31:0] o_quat_y_bits,
    output logic [31:0] o_quat_z_bits,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]        r_window [FRAME_BYTES];
    logic [7:0]        n_window [FRAME_BYTES];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [7:0]        r_device_id;
    logic [SUM_BYTES-1:0] sum_col [8];
    logic [7:0]        sum;
    logic              accept;
    logic              trigger;
    logic              match;
    logic              fifo_full;
    t_result           res;
    t_result           out_data;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !fifo_full;

    // Configuration writes and reads.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEVICE_ID) ? {24'd0, r_device_id} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= 8'd0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_DEVICE_ID)) begin
            r_device_id <= pwdata[7:0];
        end
    end

    // Window update: append while filling, shift left once full.
    always_comb begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (r_fill[FILL_W-1]) begin
                n_window[i] = (i == FRAME_BYTES - 1) ? i_rx_byte : r_window[(i + 1) % FRAME_BYTES];
            end else begin
                n_window[i] = (r_fill[IDX_W-1:0] == IDX_W'(i)) ? i_rx_byte : r_window[i];
            end
        end
    end

    // Checksum as a balanced XOR tree over the payload bytes.
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            for (int j = 0; j < SUM_BYTES; j++) begin
                sum_col[k][j] = n_window[SUM_FIRST + j][k];
            end
        end
        for (int k = 0; k < 8; k++) begin
            sum[k] = SUM_SEED[k] ^ (^sum_col[k]);
        end
    end

    assign trigger = (i_rx_byte == SYNC_TAIL) && (n_window[0] == SYNC_HEAD);
    assign match   = (sum == n_window[1]) && (n_window[2] == r_device_id);

    // Result assembly; a rejected frame carries zero pose words.
    always_comb begin
        res = '0;
        if (match) begin
            res.frame_status = STATUS_OK;
            res.pos_x_bits  = {n_window[6],  n_window[5],  n_window[4],  n_window[3]};
            res.pos_y_bits  = {n_window[10], n_window[9],  n_window[8],  n_window[7]};
            res.pos_z_bits  = {~n_window[14][7], n_window[14][6:0], n_window[13],
                               n_window[12], n_window[11]};
            res.quat_w_bits = {n_window[30], n_window[29], n_window[28], n_window[27]};
            res.quat_x_bits = {n_window[18], n_window[17], n_window[16], n_window[15]};
            res.quat_y_bits = {n_window[22], n_window[21], n_window[20], n_window[19]};
            res.quat_z_bits = {n_window[26], n_window[25], n_window[24], n_window[23]};
        end else begin
            res.frame_status = STATUS_REJECT;
        end
    end

    // Fill count: cleared by an accepted frame, saturates at the window size.
    always_comb begin
        if (trigger && match) begin
            n_fill = '0;
        end else if (r_fill[FILL_W-1]) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_window[i] <= 8'd0;
            end
        end else if (accept) begin
            r_fill <= n_fill;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_window[i] <= n_window[i];
            end
        end
    end

    // Result queue toward the output channel.
    pfd_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && trigger),
        .i_data  (res),
        .o_full  (fifo_full),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (out_data)
    );

    assign o_frame_status = out_data.frame_status;
    assign o_pos_x_bits   = out_data.pos_x_bits;
    assign o_pos_y_bits   = out_data.pos_y_bits;
    assign o_pos_z_bits   = out_data.pos_z_bits;
    assign o_quat_w_bits  = out_data.quat_w_bits;
    assign o_quat_x_bits  = out_data.quat_x_bits;
    assign o_quat_y_bits  = out_data.quat_y_bits;
    assign o_quat_z_bits  = out_data.quat_z_bits;

    `PFD_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(FRAME_BYTES))
    `PFD_ASSERT_NEXT(a_match_clears_fill, i_clk, i_rst_n, accept && trigger && match, r_fill == '0)
    `PFD_ASSERT_NEXT(a_idle_holds_fill, i_clk, i_rst_n, !accept, $stable(r_fill))

endmodule

FILE: hw/rtl/pfd_out_fifo.sv
// Two-entry result queue that decouples the deframer from the output channel.
// Depends on pfd_pkg for the result type and on the assertion macro header.
`timescale 1ns / 1ps
`include "pose_frame_deframer_core_macros.svh"

module pfd_out_fifo
    import pfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result      r_mem [2];
    logic         r_head;
    logic [1:0]   r_count;
    logic         n_head;
    logic [1:0]   n_count;
    logic         pop;
    logic         wr_idx;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign wr_idx  = r_head ^ r_count[0];
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_head];

    // Pointer and occupancy update for each transfer in and out.
    always_comb begin
        n_head  = pop ? ~r_head : r_head;
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[wr_idx] <= i_data;
        end
    end

    `PFD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= 2'd2)
    `PFD_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, o_full && !i_ready, r_count == 2'd2)
    `PFD_ASSERT_NEXT(a_head_stalls, i_clk, i_rst_n, o_valid && !i_ready, $stable(r_head))

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for pose_frame_deframer_core: byte stream in, pose results out.
// Depends on pfd_pkg and the deframer RTL; keeps its own window model to predict results.
`timescale 1ns / 1ps

module tb_top;
    import pfd_pkg::*;

    localparam int          CLK_HALF       = 5;
    localparam int          RESET_CYCLES   = 7;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          RANDOM_ITEMS   = 1500;
    localparam int          PHASES         = 6;
    localparam int unsigned TIMEOUT_NS     = 5_000_000;
    localparam logic [2:0]  ADDR_DEVICE_ID = {REG_DEVICE_ID, 2'b00};
    localparam logic [2:0]  ADDR_UNMAPPED  = 3'd4;

    typedef logic [FRAME_BYTES-1:0][7:0] t_window;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_ID,
        FRAME_CUT
    } t_frame_kind;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'h0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_frame_status;
    logic [31:0] o_pos_x_bits;
    logic [31:0] o_pos_y_bits;
    logic [31:0] o_pos_z_bits;
    logic [31:0] o_quat_w_bits;
    logic [31:0] o_quat_x_bits;
    logic [31:0] o_quat_y_bits;
    logic [31:0] o_quat_z_bits;
    logic [31:0] prdata;
    logic        pready;

    // Model of the receive window and the expected pose results.
    t_window     pred_window    = '0;
    int unsigned pred_fill      = 0;
    logic [7:0]  pred_device_id = 8'h00;
    t_result     pose_expected_q[$];
    t_result     expected_pose;

    int unsigned fail_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned out_stall  = 0;
    bit          idle_on    = 1'b1;

    pose_frame_deframer_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_status (o_frame_status),
        .o_pos_x_bits   (o_pos_x_bits),
        .o_pos_y_bits   (o_pos_y_bits),
        .o_pos_z_bits   (o_pos_z_bits),
        .o_quat_w_bits  (o_quat_w_bits),
        .o_quat_x_bits  (o_quat_x_bits),
        .o_quat_y_bits  (o_quat_y_bits),
        .o_quat_z_bits  (o_quat_z_bits),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Free-running clock.
    always #CLK_HALF i_clk = ~i_clk;

    // Seed 19 folded with the checksum span of the window.
    function automatic logic [7:0] frame_checksum(input t_window w);
        logic [7:0] s;
        s = SUM_SEED;
        for (int i = SUM_FIRST; i <= SUM_LAST; i++) begin
            s ^= w[i];
        end
        return s;
    endfunction

    // Little-endian word starting at byte p of the window.
    function automatic logic [31:0] window_word(input t_window w, input int p);
        return {w[p+3], w[p+2], w[p+1], w[p]};
    endfunction

    // Update the window model with one accepted byte and queue any result.
    task automatic deframe_byte(input logic [7:0] b);
        t_result r;
        if (pred_fill >= FRAME_BYTES) begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                pred_window[i] = pred_window[i+1];
            end
            pred_window[FRAME_BYTES-1] = b;
        end else begin
            pred_window[pred_fill] = b;
            pred_fill++;
        end
        if (b == SYNC_TAIL && pred_window[0] == SYNC_HEAD) begin
            r = '0;
            if (frame_checksum(pred_window) == pred_window[1] &&
                pred_window[2] == pred_device_id) begin
                // Accepted: the window is kept, only the fill count restarts.
                pred_fill      = 0;
                r.frame_status = STATUS_OK;
                r.pos_x_bits   = window_word(pred_window, 3);
                r.pos_y_bits   = window_word(pred_window, 7);
                r.pos_z_bits   = window_word(pred_window, 11) ^ 32'h8000_0000;
                r.quat_x_bits  = window_word(pred_window, 15);
                r.quat_y_bits  = window_word(pred_window, 19);
                r.quat_z_bits  = window_word(pred_window, 23);
                r.quat_w_bits  = window_word(pred_window, 27);
            end else begin
                r.frame_status = STATUS_REJECT;
            end
            pose_expected_q.push_back(r);
        end
    endtask

    // Present one byte, with an occasional idle burst first, and wait for its transfer.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // Hold the byte channel idle until every queued result has come out.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pose_expected_q.size() != 0);
    endtask

    // Drained, plus enough cycles for a non-triggering byte to settle.
    task automatic wait_block_idle();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_DEVICE_ID) begin
            pred_device_id = data[7:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the id register and confirm it reads back.
    task automatic set_device_id(input logic [7:0] id);
        logic [31:0] rd;
        apb_write(ADDR_DEVICE_ID, {16'($urandom_range(0, 16'hFFFF)), 8'h00, id});
        apb_read(ADDR_DEVICE_ID, rd);
        if (rd !== {24'h0, pred_device_id}) begin
            $error("device_id mismatch: expected %h, actual %h", {24'h0, pred_device_id}, rd);
            fail_count++;
        end
    endtask

    // Full 32-byte frame with random or flat payload; a cut frame stops early.
    task automatic send_frame(input t_frame_kind kind);
        t_window     f;
        int unsigned n;
        int unsigned pat;
        pat = $urandom_range(0, 9);
        f[0] = SYNC_HEAD;
        f[FRAME_BYTES-1] = SYNC_TAIL;
        for (int i = SUM_FIRST; i <= SUM_LAST; i++) begin
            f[i] = (pat == 0) ? 8'h00 : (pat == 1) ? 8'hFF : 8'($urandom);
        end
        f[2] = pred_device_id;
        if (kind == FRAME_BAD_ID) begin
            f[2] ^= 8'($urandom_range(1, 255));
        end
        f[1] = frame_checksum(f);
        if (kind == FRAME_BAD_SUM) begin
            f[1] ^= 8'($urandom_range(1, 255));
        end
        n = (kind == FRAME_CUT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
        for (int i = 0; i < n; i++) begin
            send_byte(f[i]);
        end
    endtask

    // Four-byte frame that closes on stale window bytes; only valid with an empty window.
    task automatic send_stale_frame(input t_frame_kind kind);
        t_window w;
        w    = pred_window;
        w[0] = SYNC_HEAD;
        w[2] = pred_device_id;
        if (kind == FRAME_BAD_ID) begin
            w[2] ^= 8'($urandom_range(1, 255));
        end
        w[3] = SYNC_TAIL;
        w[1] = frame_checksum(w);
        if (kind == FRAME_BAD_SUM) begin
            w[1] ^= 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < 4; i++) begin
            send_byte(w[i]);
        end
    endtask

    // Short run of random bytes, biased toward the delimiters.
    task automatic send_noise();
        int unsigned n;
        int unsigned sel;
        n = $urandom_range(1, 8);
        repeat (n) begin
            sel = $urandom_range(0, 5);
            if (sel == 0) begin
                send_byte(SYNC_HEAD);
            end else if (sel == 1) begin
                send_byte(SYNC_TAIL);
            end else begin
                send_byte(8'($urandom));
            end
        end
    endtask

    // Frames that close on the zeroed window after reset, then on the last frame.
    task automatic test_stale_window();
        send_stale_frame(FRAME_GOOD);
        send_stale_frame(FRAME_GOOD);
    endtask

    // Checksum reject, then a second trailer that is appended and re-checks the window.
    task automatic test_frame_rejects();
        send_stale_frame(FRAME_BAD_SUM);
        send_byte(SYNC_TAIL);
    endtask

    // Bytes that cannot trigger a check, extremes included.
    task automatic test_no_trigger();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_HEAD);
    endtask

    // Unmapped writes are dropped; id extremes steer acceptance.
    task automatic test_config_regs();
        wait_block_idle();
        apb_write(ADDR_UNMAPPED, $urandom);
        set_device_id(8'hFF);
        send_frame(FRAME_GOOD);
        send_frame(FRAME_BAD_ID);
        wait_block_idle();
        set_device_id(8'h00);
        send_frame(FRAME_GOOD);
    endtask

    // Mostly well-formed frames with random content, mixed with broken ones and noise.
    task automatic test_random_frames();
        int unsigned target;
        int unsigned pressure_at;
        int unsigned sel;
        bit          pressure_done;
        for (int p = 0; p < PHASES; p++) begin
            wait_block_idle();
            set_device_id((p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom));
            if (p == PHASES - 1) begin
                idle_on = 1'b0;
            end
            target        = bytes_sent + RANDOM_ITEMS / PHASES;
            pressure_at   = bytes_sent + $urandom_range(0, RANDOM_ITEMS / PHASES);
            pressure_done = 1'b0;
            while (bytes_sent < target) begin
                if (!pressure_done && bytes_sent >= pressure_at) begin
                    wait_results_drained();
                    pressure_done = 1'b1;
                end
                sel = $urandom_range(0, 99);
                if (sel < 50) begin
                    send_frame(FRAME_GOOD);
                end else if (sel < 60) begin
                    send_frame(FRAME_BAD_SUM);
                end else if (sel < 68) begin
                    send_frame(FRAME_BAD_ID);
                end else if (sel < 76) begin
                    send_frame(FRAME_CUT);
                end else if (sel < 88) begin
                    if (pred_fill == 0) begin
                        case ($urandom_range(0, 2))
                            0: send_stale_frame(FRAME_GOOD);
                            1: send_stale_frame(FRAME_BAD_SUM);
                            default: send_stale_frame(FRAME_BAD_ID);
                        endcase
                    end else begin
                        send_frame(FRAME_GOOD);
                    end
                end else begin
                    send_noise();
                end
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    // Result receiver: stalls in random bursts until the last phase.
    always @(posedge i_clk) begin
        if (out_stall != 0) begin
            out_stall   <= out_stall - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_stall   <= $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare every result transfer with the oldest pending frame.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pose_expected_q.size() == 0) begin
                $error("result transfer with no frame check pending");
                fail_count++;
            end else begin
                expected_pose = pose_expected_q.pop_front();
                compare_field("frame_status", 32'(expected_pose.frame_status),
                              32'(o_frame_status));
                compare_field("pos_x_bits", expected_pose.pos_x_bits, o_pos_x_bits);
                compare_field("pos_y_bits", expected_pose.pos_y_bits, o_pos_y_bits);
                compare_field("pos_z_bits", expected_pose.pos_z_bits, o_pos_z_bits);
                compare_field("quat_w_bits", expected_pose.quat_w_bits, o_quat_w_bits);
                compare_field("quat_x_bits", expected_pose.quat_x_bits, o_quat_x_bits);
                compare_field("quat_y_bits", expected_pose.quat_y_bits, o_quat_y_bits);
                compare_field("quat_z_bits", expected_pose.quat_z_bits, o_quat_z_bits);
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_stale_window();
        test_frame_rejects();
        test_no_trigger();
        test_config_regs();
        test_random_frames();
        wait_results_drained();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

endmodule
